/* sv/hist2d_pkg.sv */
// ----------------------------------------------------------------------------
// hist2d_pkg: shared types and codes of the two-dimensional histogrammer
// Opcodes, outcome codes, configuration register indexes, the command kinds
// that travel from the classifier to the bin-update engine, and defaults.
// ----------------------------------------------------------------------------
package hist2d_pkg;

  // Default geometry of the bin store.
  localparam int unsigned MAX_X_BINS_DEF  = 256;
  localparam int unsigned MAX_Y_BINS_DEF  = 256;
  localparam int unsigned COUNT_WIDTH_DEF = 32;

  // Depth of the command queue between classifier and update engine.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Configuration port.
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] CFG_X_LOW_EDGE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_X_HIGH_EDGE  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_X_BINS_UNIT  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_X_BIN_COUNT  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_Y_LOW_EDGE   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_Y_HIGH_EDGE  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_Y_BINS_UNIT  = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_Y_BIN_COUNT  = 3'd7;

  // Input opcodes.
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Result outcome codes.
  localparam logic [2:0] OUT_BINNED    = 3'd0;
  localparam logic [2:0] OUT_UNDERFLOW = 3'd1;
  localparam logic [2:0] OUT_OVERFLOW  = 3'd2;
  localparam logic [2:0] OUT_ACCESS    = 3'd3;
  localparam logic [2:0] OUT_BAD       = 3'd4;

  // Per-axis configuration.
  typedef struct packed {
    logic [15:0] low_edge;
    logic [15:0] high_edge;
    logic [23:0] bins_per_unit;
    logic [8:0]  bin_count;
  } axis_cfg_t;

  // What the update engine has to do with one queued command.
  typedef enum logic [2:0] {
    KIND_ADD   = 3'd0,
    KIND_UNDER = 3'd1,
    KIND_OVER  = 3'd2,
    KIND_READ  = 3'd3,
    KIND_WRITE = 3'd4,
    KIND_NONE  = 3'd5
  } cmd_kind_t;

  localparam int unsigned KIND_W = $bits(cmd_kind_t);

endpackage

/* sv/histogram_2d_accumulator.sv */
// ----------------------------------------------------------------------------
// histogram_2d_accumulator: two-dimensional event histogrammer
// Bins (x,y) event pairs into a bin store, counts underflow and overflow
// events, and gives read and write access to single bins.
// ----------------------------------------------------------------------------
// Usage:
// Each input beat carries an opcode (add event, read bin, write bin) and its
// operands; every accepted beat gives exactly one result beat, in order, with
// the bin contents on a read, the running underflow and overflow totals and
// an outcome code. The configuration port is always ready; write it only
// while no item is in flight.
// An accepted beat passes through the command queue, then the update engine
// pops it in its idle state and finishes it in its execute state, so the
// engine takes a new command only after it is through with the last one.
// After reset the bin store is cleared one entry per cycle, and in_stall stays
// high during that pass. When the receiver stalls, the result register holds
// its beat, the update engine waits, and once the four-entry command queue
// fills the block raises in_stall.
// ----------------------------------------------------------------------------
module histogram_2d_accumulator #(
  parameter int unsigned MAX_X_BINS  = hist2d_pkg::MAX_X_BINS_DEF,
  parameter int unsigned MAX_Y_BINS  = hist2d_pkg::MAX_Y_BINS_DEF,
  parameter int unsigned COUNT_WIDTH = hist2d_pkg::COUNT_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration write channel.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [hist2d_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hist2d_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Input channel.
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_opcode,
  input  logic [15:0]                        in_x_value,
  input  logic [15:0]                        in_y_value,
  input  logic [15:0]                        in_weight,
  input  logic [7:0]                         in_bin_x,
  input  logic [7:0]                         in_bin_y,
  input  logic [31:0]                        in_write_count,
  // Result channel.
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [31:0]                        out_bin_count,
  output logic [31:0]                        out_underflow_total,
  output logic [31:0]                        out_overflow_total,
  output logic [2:0]                         out_outcome
);

  // Bin store address: y bin times MAX_X_BINS plus x bin.
  localparam int unsigned DEPTH = MAX_X_BINS * MAX_Y_BINS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned QW    = hist2d_pkg::KIND_W + AW + COUNT_WIDTH;

  logic                   clearing;
  logic                   q_push, q_pop, q_empty, q_full;
  hist2d_pkg::cmd_kind_t  push_kind;
  logic [AW-1:0]          push_addr;
  logic [COUNT_WIDTH-1:0] push_data;
  logic [QW-1:0]          head;

  // Configuration writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  hist2d_front #(
    .MAX_X_BINS  (MAX_X_BINS),
    .MAX_Y_BINS  (MAX_Y_BINS),
    .COUNT_WIDTH (COUNT_WIDTH),
    .AW          (AW)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_x_value     (in_x_value),
    .in_y_value     (in_y_value),
    .in_weight      (in_weight),
    .in_bin_x       (in_bin_x),
    .in_bin_y       (in_bin_y),
    .in_write_count (in_write_count),
    .clearing       (clearing),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_kind         (push_kind),
    .q_addr         (push_addr),
    .q_data         (push_data)
  );

  // The queue carries kind, address and operand as one packed word.
  hist2d_fifo #(
    .WIDTH (QW)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({push_kind, push_addr, push_data}),
    .pop       (q_pop),
    .head_data (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  hist2d_back #(
    .MAX_X_BINS  (MAX_X_BINS),
    .MAX_Y_BINS  (MAX_Y_BINS),
    .COUNT_WIDTH (COUNT_WIDTH),
    .AW          (AW)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_kind              (hist2d_pkg::cmd_kind_t'(head[QW-1 -: hist2d_pkg::KIND_W])),
    .q_addr              (head[COUNT_WIDTH +: AW]),
    .q_data              (head[COUNT_WIDTH-1:0]),
    .q_pop               (q_pop),
    .clearing            (clearing),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_bin_count       (out_bin_count),
    .out_underflow_total (out_underflow_total),
    .out_overflow_total  (out_overflow_total),
    .out_outcome         (out_outcome)
  );

`ifndef NO_ASSERTIONS
  // No input beat may enter while the bin store is still being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !(in_valid && !in_stall))
    else $error("input beat accepted during bin store clear");

  // The classifier never pushes into a full queue.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command pushed into full queue");

  // The engine never pops an empty queue.
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("command popped from empty queue");

  // Only a bin access reports bin contents.
  a_count_only_on_access: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_outcome != hist2d_pkg::OUT_ACCESS)) |-> (out_bin_count == '0))
    else $error("nonzero bin count on a result that is not an access");
`endif

endmodule

/* sv/hist2d_fifo.sv */
// ----------------------------------------------------------------------------
// hist2d_fifo: short command queue
// Register-based first-in first-out buffer that decouples the classifier
// from the bin-update engine.
// ----------------------------------------------------------------------------
module hist2d_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             empty,
  output logic             full
);

  localparam int unsigned DEPTH = hist2d_pkg::QUEUE_DEPTH;
  localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW  = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  count_r, count_nxt;

  assign empty     = (count_r == '0);
  assign full      = (count_r == CNTW'(DEPTH));
  assign head_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* sv/hist2d_front.sv */
// ----------------------------------------------------------------------------
// hist2d_front: configuration registers and event classifier
// Accepts input beats, sorts add events into underflow, overflow or a bin
// address, checks read and write indexes, and pushes one command per beat.
// ----------------------------------------------------------------------------
module hist2d_front #(
  parameter int unsigned MAX_X_BINS  = hist2d_pkg::MAX_X_BINS_DEF,
  parameter int unsigned MAX_Y_BINS  = hist2d_pkg::MAX_Y_BINS_DEF,
  parameter int unsigned COUNT_WIDTH = hist2d_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned AW          = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  input  logic [hist2d_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hist2d_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_opcode,
  input  logic [15:0]                        in_x_value,
  input  logic [15:0]                        in_y_value,
  input  logic [15:0]                        in_weight,
  input  logic [7:0]                         in_bin_x,
  input  logic [7:0]                         in_bin_y,
  input  logic [31:0]                        in_write_count,
  input  logic                               clearing,
  input  logic                               q_full,
  output logic                               q_push,
  output hist2d_pkg::cmd_kind_t              q_kind,
  output logic [AW-1:0]                      q_addr,
  output logic [COUNT_WIDTH-1:0]             q_data
);

  localparam int unsigned XIW = (MAX_X_BINS > 1) ? $clog2(MAX_X_BINS) : 1;
  localparam int unsigned YIW = (MAX_Y_BINS > 1) ? $clog2(MAX_Y_BINS) : 1;
  localparam int unsigned NXW = $clog2(MAX_X_BINS + 1);
  localparam int unsigned NYW = $clog2(MAX_Y_BINS + 1);

  hist2d_pkg::axis_cfg_t x_cfg_r, x_cfg_nxt;
  hist2d_pkg::axis_cfg_t y_cfg_r, y_cfg_nxt;

  logic [NXW-1:0] nx;
  logic [NYW-1:0] ny;
  logic [15:0]    dx, dy;
  logic [39:0]    prod_x, prod_y;
  logic [23:0]    raw_x, raw_y;
  logic [XIW-1:0] ix;
  logic [YIW-1:0] iy;
  logic           below, above, in_range;
  logic [31:0]    add_addr, acc_addr;

  // Configuration writes.
  always_comb begin
    x_cfg_nxt = x_cfg_r;
    y_cfg_nxt = y_cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        hist2d_pkg::CFG_X_LOW_EDGE:  x_cfg_nxt.low_edge      = cfg_data[15:0];
        hist2d_pkg::CFG_X_HIGH_EDGE: x_cfg_nxt.high_edge     = cfg_data[15:0];
        hist2d_pkg::CFG_X_BINS_UNIT: x_cfg_nxt.bins_per_unit = cfg_data;
        hist2d_pkg::CFG_X_BIN_COUNT: x_cfg_nxt.bin_count     = cfg_data[8:0];
        hist2d_pkg::CFG_Y_LOW_EDGE:  y_cfg_nxt.low_edge      = cfg_data[15:0];
        hist2d_pkg::CFG_Y_HIGH_EDGE: y_cfg_nxt.high_edge     = cfg_data[15:0];
        hist2d_pkg::CFG_Y_BINS_UNIT: y_cfg_nxt.bins_per_unit = cfg_data;
        hist2d_pkg::CFG_Y_BIN_COUNT: y_cfg_nxt.bin_count     = cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_cfg_r <= '{low_edge: 16'd0, high_edge: 16'hFFFF, bins_per_unit: 24'd256,
                   bin_count: 9'd256};
      y_cfg_r <= '{low_edge: 16'd0, high_edge: 16'hFFFF, bins_per_unit: 24'd256,
                   bin_count: 9'd256};
    end else begin
      x_cfg_r <= x_cfg_nxt;
      y_cfg_r <= y_cfg_nxt;
    end
  end

  // Bins in use: zero means one bin, anything above the store size saturates.
  always_comb begin
    if (x_cfg_r.bin_count == '0) begin
      nx = NXW'(1);
    end else if (32'(x_cfg_r.bin_count) > 32'(MAX_X_BINS)) begin
      nx = NXW'(MAX_X_BINS);
    end else begin
      nx = NXW'(x_cfg_r.bin_count);
    end
    if (y_cfg_r.bin_count == '0) begin
      ny = NYW'(1);
    end else if (32'(y_cfg_r.bin_count) > 32'(MAX_Y_BINS)) begin
      ny = NYW'(MAX_Y_BINS);
    end else begin
      ny = NYW'(y_cfg_r.bin_count);
    end
  end

  // Bin index per axis, clamped to the last bin so the high edge lands inside.
  always_comb begin
    dx     = in_x_value - x_cfg_r.low_edge;
    dy     = in_y_value - y_cfg_r.low_edge;
    prod_x = 40'(dx) * 40'(x_cfg_r.bins_per_unit);
    prod_y = 40'(dy) * 40'(y_cfg_r.bins_per_unit);
    raw_x  = prod_x[39:16];
    raw_y  = prod_y[39:16];
    ix     = (32'(raw_x) >= 32'(nx)) ? XIW'(nx - 1'b1) : XIW'(raw_x);
    iy     = (32'(raw_y) >= 32'(ny)) ? YIW'(ny - 1'b1) : YIW'(raw_y);
  end

  always_comb begin
    below    = (in_x_value < x_cfg_r.low_edge) || (in_y_value < y_cfg_r.low_edge);
    above    = (in_x_value > x_cfg_r.high_edge) || (in_y_value > y_cfg_r.high_edge);
    in_range = (32'(in_bin_x) < 32'(nx)) && (32'(in_bin_y) < 32'(ny));
    add_addr = 32'(iy) * 32'(MAX_X_BINS) + 32'(ix);
    acc_addr = 32'(in_bin_y) * 32'(MAX_X_BINS) + 32'(in_bin_x);
  end

  // Command build.
  always_comb begin
    q_kind = hist2d_pkg::KIND_NONE;
    q_addr = AW'(acc_addr);
    q_data = COUNT_WIDTH'(in_write_count);
    case (in_opcode)
      hist2d_pkg::OP_ADD: begin
        q_addr = AW'(add_addr);
        q_data = COUNT_WIDTH'(in_weight);
        if (below) begin
          q_kind = hist2d_pkg::KIND_UNDER;
        end else if (above) begin
          q_kind = hist2d_pkg::KIND_OVER;
        end else begin
          q_kind = hist2d_pkg::KIND_ADD;
        end
      end
      hist2d_pkg::OP_READ: begin
        q_kind = in_range ? hist2d_pkg::KIND_READ : hist2d_pkg::KIND_NONE;
      end
      hist2d_pkg::OP_WRITE: begin
        q_kind = in_range ? hist2d_pkg::KIND_WRITE : hist2d_pkg::KIND_NONE;
      end
      default: begin
        q_kind = hist2d_pkg::KIND_NONE;
      end
    endcase
  end

  assign in_stall = q_full || clearing;
  assign q_push   = in_valid && !in_stall;

endmodule

/* sv/hist2d_back.sv */
// ----------------------------------------------------------------------------
// hist2d_back: bin store and update engine
// Clears the bin store after reset, then reads, updates or writes one bin
// per queued add, read or write command, keeps the underflow and overflow
// totals, and holds the result register.
// ----------------------------------------------------------------------------
module hist2d_back #(
  parameter int unsigned MAX_X_BINS  = hist2d_pkg::MAX_X_BINS_DEF,
  parameter int unsigned MAX_Y_BINS  = hist2d_pkg::MAX_Y_BINS_DEF,
  parameter int unsigned COUNT_WIDTH = hist2d_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned AW          = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  hist2d_pkg::cmd_kind_t  q_kind,
  input  logic [AW-1:0]          q_addr,
  input  logic [COUNT_WIDTH-1:0] q_data,
  output logic                   q_pop,
  output logic                   clearing,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [31:0]            out_bin_count,
  output logic [31:0]            out_underflow_total,
  output logic [31:0]            out_overflow_total,
  output logic [2:0]             out_outcome
);

  localparam int unsigned DEPTH = MAX_X_BINS * MAX_Y_BINS;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [COUNT_WIDTH-1:0] mem [DEPTH];

  logic [AW-1:0]          clr_addr_r, clr_addr_nxt;
  hist2d_pkg::cmd_kind_t  kind_r;
  logic [AW-1:0]          addr_r;
  logic [COUNT_WIDTH-1:0] data_r;
  logic [COUNT_WIDTH-1:0] rdata_r;
  logic [31:0]            under_r, under_nxt;
  logic [31:0]            over_r, over_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [31:0]            res_count_r, res_count_nxt;
  logic [2:0]             res_outcome_r, res_outcome_nxt;

  logic                   fire;
  logic [COUNT_WIDTH:0]   sum;
  logic [COUNT_WIDTH-1:0] sat_sum;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;

  assign clearing = (state_r == ST_CLEAR);
  assign q_pop    = (state_r == ST_IDLE) && !q_empty;
  assign fire     = (state_r == ST_EXEC) && (!out_valid_r || !out_stall);

  always_comb begin
    sum     = {1'b0, rdata_r} + {1'b0, data_r};
    sat_sum = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
  end

  always_comb begin
    state_nxt       = state_r;
    clr_addr_nxt    = clr_addr_r;
    under_nxt       = under_r;
    over_nxt        = over_r;
    out_valid_nxt   = out_valid_r && out_stall;
    res_count_nxt   = res_count_r;
    res_outcome_nxt = res_outcome_r;
    mem_we          = 1'b0;
    mem_waddr       = addr_r;
    mem_wdata       = data_r;
    case (state_r)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (fire) begin
          state_nxt       = ST_IDLE;
          out_valid_nxt   = 1'b1;
          res_count_nxt   = '0;
          res_outcome_nxt = hist2d_pkg::OUT_BAD;
          case (kind_r)
            hist2d_pkg::KIND_ADD: begin
              mem_we          = 1'b1;
              mem_wdata       = sat_sum;
              res_outcome_nxt = hist2d_pkg::OUT_BINNED;
            end
            hist2d_pkg::KIND_UNDER: begin
              if (under_r != '1) begin
                under_nxt = under_r + 1'b1;
              end
              res_outcome_nxt = hist2d_pkg::OUT_UNDERFLOW;
            end
            hist2d_pkg::KIND_OVER: begin
              if (over_r != '1) begin
                over_nxt = over_r + 1'b1;
              end
              res_outcome_nxt = hist2d_pkg::OUT_OVERFLOW;
            end
            hist2d_pkg::KIND_READ: begin
              res_count_nxt   = 32'(rdata_r);
              res_outcome_nxt = hist2d_pkg::OUT_ACCESS;
            end
            hist2d_pkg::KIND_WRITE: begin
              mem_we          = 1'b1;
              res_outcome_nxt = hist2d_pkg::OUT_ACCESS;
            end
            default: begin
              res_outcome_nxt = hist2d_pkg::OUT_BAD;
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      under_r     <= '0;
      over_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      under_r     <= under_nxt;
      over_r      <= over_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Command and result payload registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r <= q_kind;
      addr_r <= q_addr;
      data_r <= q_data;
    end
    res_count_r   <= res_count_nxt;
    res_outcome_r <= res_outcome_nxt;
  end

  // Bin store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rdata_r <= mem[q_addr];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_bin_count       = res_count_r;
  assign out_underflow_total = under_r;
  assign out_overflow_total  = over_r;
  assign out_outcome         = res_outcome_r;

endmodule

/* dv/histogram_2d_accumulator_test.sv */
// ----------------------------------------------------------------------------
// histogram_2d_accumulator_test: self-checking bench for the 2D histogrammer
// Drives add, read and write beats under random sender bursts and receiver
// stalls, predicts every result beat from a local copy of the bin store, the
// axis setup and the underflow and overflow totals, and compares in order.
// ----------------------------------------------------------------------------
module histogram_2d_accumulator_test;

  // Cycles without any accepted beat before the run is declared hung.
  localparam int unsigned IDLE_LIMIT      = 250000;
  // Length of the receiver hold-off that fills the command queue.
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned STORE_DEPTH     = hist2d_pkg::MAX_X_BINS_DEF
                                            * hist2d_pkg::MAX_Y_BINS_DEF;
  localparam int unsigned RANDOM_PHASES   = 7;
  localparam int unsigned PHASE_ITEMS     = 200;
  // The opcode that the block has no use for.
  localparam logic [1:0]  OP_SPARE        = 2'd3;
  localparam logic [31:0] COUNT_TOP       = 32'hFFFF_FFFF;
  localparam logic        X_SIDE          = 1'b0;
  localparam logic        Y_SIDE          = 1'b1;

  typedef longint unsigned u64_t;

  // One input beat, one field per port.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] x_value;
    logic [15:0] y_value;
    logic [15:0] weight;
    logic [7:0]  bin_x;
    logic [7:0]  bin_y;
    logic [31:0] write_count;
  } hist_item_t;

  // One result beat.
  typedef struct packed {
    logic [31:0] bin_count;
    logic [31:0] underflow_total;
    logic [31:0] overflow_total;
    logic [2:0]  outcome;
  } hist_result_t;

  logic                               clk = 1'b0;
  logic                               rst_n;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [hist2d_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [hist2d_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                               in_valid;
  logic                               in_stall;
  logic [1:0]                         in_opcode;
  logic [15:0]                        in_x_value;
  logic [15:0]                        in_y_value;
  logic [15:0]                        in_weight;
  logic [7:0]                         in_bin_x;
  logic [7:0]                         in_bin_y;
  logic [31:0]                        in_write_count;
  logic                               out_valid;
  logic                               out_stall;
  logic [31:0]                        out_bin_count;
  logic [31:0]                        out_underflow_total;
  logic [31:0]                        out_overflow_total;
  logic [2:0]                         out_outcome;

  histogram_2d_accumulator dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_x_value          (in_x_value),
    .in_y_value          (in_y_value),
    .in_weight           (in_weight),
    .in_bin_x            (in_bin_x),
    .in_bin_y            (in_bin_y),
    .in_write_count      (in_write_count),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_bin_count       (out_bin_count),
    .out_underflow_total (out_underflow_total),
    .out_overflow_total  (out_overflow_total),
    .out_outcome         (out_outcome)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local image of the block: axis setup, bin store and the two totals.
  hist2d_pkg::axis_cfg_t x_axis;
  hist2d_pkg::axis_cfg_t y_axis;
  logic [31:0]  bin_image [STORE_DEPTH];
  logic [31:0]  under_total;
  logic [31:0]  over_total;

  // Results that have been predicted but not yet seen, oldest first.
  hist_result_t awaited_tallies [$];

  int unsigned  mismatch_count = 0;
  int unsigned  idle_cycles    = 0;
  int unsigned  burst_left     = 0;
  // Set by a test to make the receiver hold off for that many cycles.
  int unsigned  hold_request   = 0;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // A bin count of zero means one bin; counts above the store size saturate.
  function automatic int unsigned bins_used(input logic [8:0] count,
                                            input int unsigned limit);
    if (count == 0) return 1;
    return (32'(count) > limit) ? limit : 32'(count);
  endfunction

  // Bin index on one axis for a value already known to lie within the edges.
  // The product is wide enough for a full-scale value times a 24-bit scale.
  function automatic int unsigned axis_index(input logic [15:0] v,
                                             input hist2d_pkg::axis_cfg_t a,
                                             input int unsigned limit);
    u64_t        scaled;
    int unsigned n;
    n = bins_used(a.bin_count, limit);
    scaled = ((u64_t'(v) - u64_t'(a.low_edge)) * u64_t'(a.bins_per_unit)) >> 16;
    return (scaled >= u64_t'(n)) ? n - 1 : 32'(scaled);
  endfunction

  // Applies one accepted beat to the local image and returns its result.
  function automatic hist_result_t tally_event(input hist_item_t it);
    hist_result_t r;
    int unsigned  nx;
    int unsigned  ny;
    int unsigned  addr;
    logic [32:0]  sum;
    nx = bins_used(x_axis.bin_count, hist2d_pkg::MAX_X_BINS_DEF);
    ny = bins_used(y_axis.bin_count, hist2d_pkg::MAX_Y_BINS_DEF);
    r = '0;
    case (it.opcode)
      hist2d_pkg::OP_ADD: begin
        // Underflow wins over overflow when both apply.
        if (it.x_value < x_axis.low_edge || it.y_value < y_axis.low_edge) begin
          if (under_total != COUNT_TOP) under_total++;
          r.outcome = hist2d_pkg::OUT_UNDERFLOW;
        end else if (it.x_value > x_axis.high_edge || it.y_value > y_axis.high_edge) begin
          if (over_total != COUNT_TOP) over_total++;
          r.outcome = hist2d_pkg::OUT_OVERFLOW;
        end else begin
          addr = axis_index(it.y_value, y_axis, hist2d_pkg::MAX_Y_BINS_DEF)
                 * hist2d_pkg::MAX_X_BINS_DEF
               + axis_index(it.x_value, x_axis, hist2d_pkg::MAX_X_BINS_DEF);
          sum = {1'b0, bin_image[addr]} + {17'h0, it.weight};
          bin_image[addr] = sum[32] ? COUNT_TOP : sum[31:0];
          r.outcome = hist2d_pkg::OUT_BINNED;
        end
      end
      hist2d_pkg::OP_READ, hist2d_pkg::OP_WRITE: begin
        if (it.bin_x < nx && it.bin_y < ny) begin
          addr = it.bin_y * hist2d_pkg::MAX_X_BINS_DEF + it.bin_x;
          if (it.opcode == hist2d_pkg::OP_READ) begin
            r.bin_count = bin_image[addr];
          end else begin
            bin_image[addr] = it.write_count;
          end
          r.outcome = hist2d_pkg::OUT_ACCESS;
        end else begin
          r.outcome = hist2d_pkg::OUT_BAD;
        end
      end
      default: r.outcome = hist2d_pkg::OUT_BAD;
    endcase
    r.underflow_total = under_total;
    r.overflow_total  = over_total;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Beat builders
  // ---------------------------------------------------------------------------

  function automatic hist2d_pkg::axis_cfg_t make_axis(input logic [15:0] low,
                                                      input logic [15:0] high,
                                                      input logic [23:0] scale,
                                                      input logic [8:0] count);
    hist2d_pkg::axis_cfg_t a;
    a.low_edge      = low;
    a.high_edge     = high;
    a.bins_per_unit = scale;
    a.bin_count     = count;
    return a;
  endfunction

  // Random axis setup. Most of the time the scale spreads the accepted range
  // over the bins in use; sometimes it is zero, full scale or arbitrary.
  function automatic hist2d_pkg::axis_cfg_t random_axis();
    hist2d_pkg::axis_cfg_t a;
    int unsigned span;
    int unsigned used;
    int unsigned ratio;
    a.low_edge = 16'($urandom_range(0, 40000));
    if ($urandom_range(0, 9) == 0) begin
      a.high_edge = 16'($urandom_range(0, a.low_edge));
    end else begin
      a.high_edge = 16'($urandom_range(a.low_edge, 65535));
    end
    case ($urandom_range(0, 5))
      0: a.bin_count = 9'd1;
      1: a.bin_count = 9'd256;
      2: a.bin_count = 9'd0;
      3: a.bin_count = 9'($urandom_range(257, 511));
      default: a.bin_count = 9'($urandom_range(2, 16));
    endcase
    used = bins_used(a.bin_count, hist2d_pkg::MAX_X_BINS_DEF);
    span = (a.high_edge >= a.low_edge) ? a.high_edge - a.low_edge + 1 : 1;
    ratio = (used << 16) / span;
    case ($urandom_range(0, 7))
      0: a.bins_per_unit = 24'hFF_FFFF;
      1: a.bins_per_unit = 24'h00_0000;
      2: a.bins_per_unit = 24'($urandom);
      default: a.bins_per_unit = (ratio > 32'h00FF_FFFF) ? 24'hFF_FFFF : 24'(ratio);
    endcase
    return a;
  endfunction

  function automatic hist_item_t random_fields();
    hist_item_t it;
    it.opcode      = 2'($urandom);
    it.x_value     = 16'($urandom);
    it.y_value     = 16'($urandom);
    it.weight      = 16'($urandom);
    it.bin_x       = 8'($urandom);
    it.bin_y       = 8'($urandom);
    it.write_count = $urandom;
    return it;
  endfunction

  function automatic hist_item_t event_item(input logic [15:0] x, input logic [15:0] y,
                                            input logic [15:0] w);
    hist_item_t it;
    it = random_fields();
    it.opcode  = hist2d_pkg::OP_ADD;
    it.x_value = x;
    it.y_value = y;
    it.weight  = w;
    return it;
  endfunction

  function automatic hist_item_t access_item(input logic [1:0] op, input logic [7:0] bx,
                                             input logic [7:0] by,
                                             input logic [31:0] wc);
    hist_item_t it;
    it = random_fields();
    it.opcode      = op;
    it.bin_x       = bx;
    it.bin_y       = by;
    it.write_count = wc;
    return it;
  endfunction

  // Mostly events inside the edges and accesses to bins in use, so that the
  // bins fill and reads return real counts; the rest is events with random
  // values, accesses anywhere and the spare opcode.
  function automatic hist_item_t random_item();
    hist_item_t  it;
    int unsigned pick;
    int unsigned nx;
    int unsigned ny;
    it = random_fields();
    nx = bins_used(x_axis.bin_count, hist2d_pkg::MAX_X_BINS_DEF);
    ny = bins_used(y_axis.bin_count, hist2d_pkg::MAX_Y_BINS_DEF);
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      it.opcode = hist2d_pkg::OP_ADD;
      if (x_axis.low_edge <= x_axis.high_edge) begin
        it.x_value = 16'($urandom_range(x_axis.low_edge, x_axis.high_edge));
      end
      if (y_axis.low_edge <= y_axis.high_edge) begin
        it.y_value = 16'($urandom_range(y_axis.low_edge, y_axis.high_edge));
      end
      if ($urandom_range(0, 9) == 0) it.weight = 16'hFFFF;
    end else if (pick < 70) begin
      it.opcode = hist2d_pkg::OP_ADD;
    end else if (pick < 90) begin
      it.opcode = (pick < 80) ? hist2d_pkg::OP_READ : hist2d_pkg::OP_WRITE;
      it.bin_x  = 8'($urandom_range(0, nx - 1));
      it.bin_y  = 8'($urandom_range(0, ny - 1));
    end else if (pick < 96) begin
      it.opcode = ($urandom_range(0, 1) == 0) ? hist2d_pkg::OP_READ : hist2d_pkg::OP_WRITE;
    end else begin
      it.opcode = OP_SPARE;
    end
    // Counts near the top let later adds run into saturation.
    if ($urandom_range(0, 7) == 0) it.write_count = COUNT_TOP - $urandom_range(0, 70000);
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offers one beat from the falling edge and holds it until accepted. The
  // result is predicted at the accepting edge, in acceptance order.
  task automatic send_item(input hist_item_t it);
    hist_result_t predicted;
    @(negedge clk);
    in_valid       <= 1'b1;
    in_opcode      <= it.opcode;
    in_x_value     <= it.x_value;
    in_y_value     <= it.y_value;
    in_weight      <= it.weight;
    in_bin_x       <= it.bin_x;
    in_bin_y       <= it.bin_y;
    in_write_count <= it.write_count;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = tally_event(it);
    awaited_tallies = {awaited_tallies, predicted};
  endtask

  // Same, but the sender works in bursts of random length with random gaps.
  task automatic send_paced(input hist_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    send_item(it);
  endtask

  // Stops offering beats and waits until every predicted result has come.
  task automatic pause_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_tallies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [hist2d_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [hist2d_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      hist2d_pkg::CFG_X_LOW_EDGE:  x_axis.low_edge      = data[15:0];
      hist2d_pkg::CFG_X_HIGH_EDGE: x_axis.high_edge     = data[15:0];
      hist2d_pkg::CFG_X_BINS_UNIT: x_axis.bins_per_unit = data[23:0];
      hist2d_pkg::CFG_X_BIN_COUNT: x_axis.bin_count     = data[8:0];
      hist2d_pkg::CFG_Y_LOW_EDGE:  y_axis.low_edge      = data[15:0];
      hist2d_pkg::CFG_Y_HIGH_EDGE: y_axis.high_edge     = data[15:0];
      hist2d_pkg::CFG_Y_BINS_UNIT: y_axis.bins_per_unit = data[23:0];
      default:                     y_axis.bin_count     = data[8:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_axis(input logic side, input hist2d_pkg::axis_cfg_t a);
    write_register(side ? hist2d_pkg::CFG_Y_LOW_EDGE : hist2d_pkg::CFG_X_LOW_EDGE,
                   {8'h00, a.low_edge});
    write_register(side ? hist2d_pkg::CFG_Y_HIGH_EDGE : hist2d_pkg::CFG_X_HIGH_EDGE,
                   {8'h00, a.high_edge});
    write_register(side ? hist2d_pkg::CFG_Y_BINS_UNIT : hist2d_pkg::CFG_X_BINS_UNIT,
                   a.bins_per_unit);
    write_register(side ? hist2d_pkg::CFG_Y_BIN_COUNT : hist2d_pkg::CFG_X_BIN_COUNT,
                   {15'h0000, a.bin_count});
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset geometry: 256 bins per axis, one bin per 256 input units.
  task automatic test_default_geometry();
    hist_item_t it;
    send_item(event_item(16'h0000, 16'h0000, 16'hFFFF));
    // The high edge itself must land in the last bin.
    send_item(event_item(16'hFFFF, 16'hFFFF, 16'h0001));
    send_item(event_item(16'h1234, 16'hABCD, 16'h5A5A));
    send_item(access_item(hist2d_pkg::OP_READ, 8'h00, 8'h00, 32'h0));
    send_item(access_item(hist2d_pkg::OP_READ, 8'hFF, 8'hFF, 32'h0));
    send_item(access_item(hist2d_pkg::OP_READ, 8'h12, 8'hAB, 32'h0));
    // A bin near the top saturates on the next add.
    send_item(access_item(hist2d_pkg::OP_WRITE, 8'h07, 8'h09, 32'hFFFF_FFF0));
    send_item(event_item(16'h07FF, 16'h0900, 16'hFFFF));
    send_item(access_item(hist2d_pkg::OP_READ, 8'h07, 8'h09, 32'h0));
    send_item(access_item(hist2d_pkg::OP_WRITE, 8'hFF, 8'h00, 32'hA5A5_5A5A));
    send_item(access_item(hist2d_pkg::OP_READ, 8'hFF, 8'h00, 32'h0));
    it = random_fields();
    it.opcode = OP_SPARE;
    send_item(it);
    pause_until_drained();
  endtask

  // Edges, outcome priority, bin-count limits and index range checks.
  task automatic test_edges_and_priority();
    // Four x bins at a quarter bin per unit, so the top of x clamps; a zero
    // y bin count means a single bin, and full-scale y clamps too.
    program_axis(X_SIDE, make_axis(16'd100, 16'd200, 24'h00_4000, 9'd4));
    program_axis(Y_SIDE, make_axis(16'd1000, 16'd60000, 24'hFF_FFFF, 9'd0));
    send_item(event_item(16'd99, 16'd65535, 16'd3));
    send_item(event_item(16'd201, 16'd500, 16'd3));
    send_item(event_item(16'd201, 16'd2000, 16'd3));
    send_item(event_item(16'd150, 16'd65535, 16'd3));
    send_item(event_item(16'd100, 16'd1000, 16'd5));
    send_item(event_item(16'd200, 16'd60000, 16'd7));
    send_item(access_item(hist2d_pkg::OP_READ, 8'd3, 8'd0, 32'h0));
    send_item(access_item(hist2d_pkg::OP_READ, 8'd4, 8'd0, 32'h0));
    send_item(access_item(hist2d_pkg::OP_READ, 8'd0, 8'd1, 32'h0));
    send_item(access_item(hist2d_pkg::OP_WRITE, 8'hFF, 8'hFF, 32'h1234_5678));
    pause_until_drained();

    // Low edge above high edge: nothing can be binned.
    program_axis(X_SIDE, make_axis(16'd5000, 16'd4000, 24'h00_0000, 9'h1FF));
    program_axis(Y_SIDE, make_axis(16'd0, 16'hFFFF, 24'h00_0100, 9'd256));
    send_item(event_item(16'd4500, 16'd10, 16'd1));
    send_item(event_item(16'd6000, 16'd10, 16'd1));
    pause_until_drained();

    // A zero scale puts every x into bin zero; an oversized count saturates.
    program_axis(X_SIDE, make_axis(16'd0, 16'hFFFF, 24'h00_0000, 9'h1FF));
    send_item(event_item(16'hFFFF, 16'd300, 16'd9));
    send_item(access_item(hist2d_pkg::OP_READ, 8'd0, 8'd1, 32'h0));
    send_item(access_item(hist2d_pkg::OP_READ, 8'hFF, 8'd1, 32'h0));
    pause_until_drained();
  endtask

  // Phases of random beats, each under its own geometry; the first phase
  // goes back to the reset geometry.
  task automatic test_random_phases();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) begin
        program_axis(X_SIDE, make_axis(16'd0, 16'hFFFF, 24'h00_0100, 9'd256));
        program_axis(Y_SIDE, make_axis(16'd0, 16'hFFFF, 24'h00_0100, 9'd256));
      end else begin
        program_axis(X_SIDE, random_axis());
        program_axis(Y_SIDE, random_axis());
      end
      repeat (PHASE_ITEMS) send_paced(random_item());
      pause_until_drained();
    end
  endtask

  // The receiver holds off long enough for the command queue to fill while
  // beats keep coming, so the block must stall its input. Afterwards the
  // sender stops mid-stream until every result is back.
  task automatic test_backpressure();
    hold_request = HOLD_OFF_CYCLES;
    repeat (60) send_item(random_item());
    pause_until_drained();
    repeat (15) send_paced(random_item());
    pause_until_drained();
    repeat (15) send_paced(random_item());
    pause_until_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stalls on its own pattern. Stretches without stalls, with light
  // stalls and with heavy stalls alternate; a requested hold-off overrides.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned mode_left;
    int unsigned stall_pct;
    mode_left = 0;
    stall_pct = 0;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        out_stall <= 1'b1;
        hold_request--;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(20, 200);
          case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 30;
            default: stall_pct = 75;
          endcase
        end
        mode_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result beat is matched against the oldest
  // prediction, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    hist_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (awaited_tallies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result beat: count %h under %h over %h outcome %0d",
                   out_bin_count, out_underflow_total, out_overflow_total, out_outcome);
        end
      end else begin
        want = awaited_tallies.pop_front();
        if (out_bin_count !== want.bin_count
            || out_underflow_total !== want.underflow_total
            || out_overflow_total !== want.overflow_total
            || out_outcome !== want.outcome) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result mismatch: expected count %h under %h over %h outcome %0d",
                     want.bin_count, want.underflow_total, want.overflow_total,
                     want.outcome);
            $display("                 actual   count %h under %h over %h outcome %0d",
                     out_bin_count, out_underflow_total, out_overflow_total,
                     out_outcome);
          end
        end
      end
    end
  end

  // Watchdog: any accepted beat on any channel counts as progress.
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0)
        || (out_valid === 1'b1 && out_stall === 1'b0)
        || (cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_opcode      = hist2d_pkg::OP_ADD;
    in_x_value     = '0;
    in_y_value     = '0;
    in_weight      = '0;
    in_bin_x       = '0;
    in_bin_y       = '0;
    in_write_count = '0;

    // The local image starts where the block does after its clearing pass.
    x_axis      = make_axis(16'd0, 16'hFFFF, 24'h00_0100, 9'd256);
    y_axis      = make_axis(16'd0, 16'hFFFF, 24'h00_0100, 9'd256);
    under_total = '0;
    over_total  = '0;
    for (int i = 0; i < STORE_DEPTH; i++) bin_image[i] = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The first beats simply wait out the clearing pass behind in_stall.
    test_default_geometry();
    test_edges_and_priority();
    test_random_phases();
    test_backpressure();

    if (mismatch_count == 0 && awaited_tallies.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* histogram_2d_accumulator.f */
sv/hist2d_pkg.sv
sv/hist2d_fifo.sv
sv/hist2d_front.sv
sv/hist2d_back.sv
sv/histogram_2d_accumulator.sv
dv/histogram_2d_accumulator_test.sv
